// ===== rtl/rs485_pkg.sv =====
// Package: shared types and constants for the RS485 frame transport core.
package rs485_pkg;

	localparam int MaxFrameDef = 256;
	localparam int CfgIdxW     = 3;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_RXB   = 3'd1,
		OP_TX    = 3'd2,
		OP_READ  = 3'd3,
		OP_ABORT = 3'd4
	} opcode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BAUD   = 3'd0,
		REG_STOP2  = 3'd1,
		REG_PARITY = 3'd2,
		REG_ENHI   = 3'd3,
		REG_BUSEN  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_TX   = 2'd1,
		MODE_RX   = 2'd2
	} bus_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} fsm_t;

endpackage

// ===== rtl/rs485_if.sv =====
// Interfaces: item, result and configuration channels.
interface rs485_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] now_us;
	logic [7:0]  received_byte;
	logic [8:0]  tx_length;
	logic        write_short;
	logic [8:0]  capacity;
	modport source (output valid, opcode, now_us, received_byte, tx_length, write_short,
		capacity, input ready);
	modport sink (input valid, opcode, now_us, received_byte, tx_length, write_short,
		capacity, output ready);
endinterface

interface rs485_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        drive_enable;
	logic [1:0]  bus_mode;
	logic        frame_ready;
	logic [8:0]  frame_length;
	logic [7:0]  data_byte;
	logic        last_of_frame;
	logic [31:0] sent_frame_count;
	logic [31:0] received_frame_count;
	logic [31:0] overflow_count;
	logic [31:0] write_error_count;
	modport source (output valid, accepted, drive_enable, bus_mode, frame_ready,
		frame_length, data_byte, last_of_frame, sent_frame_count, received_frame_count,
		overflow_count, write_error_count, input ready);
	modport sink (input valid, accepted, drive_enable, bus_mode, frame_ready,
		frame_length, data_byte, last_of_frame, sent_frame_count, received_frame_count,
		overflow_count, write_error_count, output ready);
endinterface

interface rs485_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rs485_half_duplex_frame_transport_core.sv =====
// Top level: RS485 half-duplex frame transport controller.
// One word is taken at a time. A tick, received byte, read or abort is executed in the
// cycle after it is taken and finished in the next one, where a read picks up the
// registered memory word. Its result is then presented and held, and the next word can
// be taken once the result leaves. An accepted transmit start also runs a restoring
// divider of the bit-time product by the baud rate, one quotient bit per cycle between
// execute and finish, before its result is presented. After each write to registers
// 0..2 the gap time is recomputed the same way, and both input ports stay stalled until
// it is done. The receive store is a single-port synchronous RAM of MAX_FRAME bytes; its
// contents are undefined until written. The result register holds until taken.
module rs485_half_duplex_frame_transport_core #(
	parameter int MAX_FRAME = rs485_pkg::MaxFrameDef
) (
	input logic clk,
	input logic arst_n,
	rs485_in_if.sink   in_ch,
	rs485_out_if.source out_ch,
	rs485_cfg_if.sink  cfg
);
	localparam int AW = $clog2(MAX_FRAME);
	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int LW = (CW > 10) ? CW : 10;   // compare width for lengths and counts
	localparam int NW = 57;   // dividend width: 257*12*1e6 < 2^42, margin
	localparam int QB = 57;

	// configuration
	logic [21:0] baud_q;
	logic        stop2_q, par_q, enhi_q, busen_q;
	// control state
	rs485_pkg::fsm_t      st_q, st_d;
	rs485_pkg::bus_mode_t mode_q;
	logic          ready_q, dir_q, div_gap_q;
	logic [CW-1:0] rx_cnt_q;
	logic [AW:0]   rd_idx_q;
	logic [31:0]   dl_q, last_q, gap_q, now_q;
	logic [31:0]   cnt_sent_q, cnt_rcv_q, cnt_ovf_q, cnt_wr_q;
	// latched item
	logic [2:0] op_q;
	logic [7:0] rxb_q;
	logic [8:0] len_q, cap_q;
	logic       sw_q;
	// memory
	logic [7:0] mem [MAX_FRAME];
	logic [7:0] rd_data_s1;
	// divider
	logic [NW-1:0] num_q, rem_q;
	logic [QB-1:0] quo_q;
	logic [6:0]    div_cnt_q;
	// result regs
	logic       acc_q, last_of_q;
	logic [7:0] dat_q;

	logic [3:0] bpc;
	logic [9:0] chars1;
	logic [NW-1:0] bits_w;
	logic [NW:0]   rem_sh;
	logic          gap_pend_q;

	assign bpc = 4'd10 + {3'd0, stop2_q} + {3'd0, par_q};

	// divider start: dividend = chars*bpc*1e6 + baud-1
	function automatic logic [NW-1:0] dividend(input logic [9:0] c, input logic [3:0] b,
		input logic [21:0] bd);
		logic [13:0] bits;
		logic [21:0] bd1;
		begin
			bits = c * b;
			bd1  = (bd == 22'd0) ? 22'd1 : bd;
			dividend = NW'(bits) * NW'(1000000) + NW'(bd1) - NW'(1);
		end
	endfunction

	logic [21:0] divisor;
	assign divisor = (baud_q == 22'd0) ? 22'd1 : baud_q;
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign chars1 = div_gap_q ? 10'd5 : {1'b0, len_q} + 10'd1;
	assign bits_w = dividend(chars1, bpc, baud_q);

	// handshakes
	assign in_ch.ready = (st_q == rs485_pkg::ST_IDLE) && !gap_pend_q;
	assign cfg.ready   = (st_q == rs485_pkg::ST_IDLE) && !gap_pend_q;

	logic in_fire, cfg_fire;
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign cfg_fire = cfg.valid && cfg.ready;

	// saturated quotient
	logic [31:0] dur;
	assign dur = (|quo_q[QB-1:32]) ? 32'hFFFF_FFFF : quo_q[31:0];

	// transmit start checks
	logic          tx_ok, tx_go;
	assign tx_ok = busen_q && len_q != 9'd0 && LW'(len_q) <= LW'(MAX_FRAME)
		&& mode_q == rs485_pkg::MODE_IDLE && !ready_q;
	assign tx_go = tx_ok && !sw_q;

	// next-state
	always_comb begin
		st_d = st_q;
		case (st_q)
			rs485_pkg::ST_IDLE: begin
				if (gap_pend_q) st_d = rs485_pkg::ST_DIV;
				else if (in_fire) st_d = rs485_pkg::ST_EXEC;
			end
			rs485_pkg::ST_EXEC: st_d = (op_q == rs485_pkg::OP_TX && tx_go) ?
				rs485_pkg::ST_DIV : rs485_pkg::ST_FIN;
			rs485_pkg::ST_DIV: if (div_cnt_q == 7'd0) st_d = rs485_pkg::ST_FIN;
			rs485_pkg::ST_FIN: st_d = div_gap_q ? rs485_pkg::ST_IDLE : rs485_pkg::ST_OUT;
			rs485_pkg::ST_OUT: if (out_ch.ready) st_d = rs485_pkg::ST_IDLE;
			default: st_d = rs485_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= rs485_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	// receive store: one port, read registered
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	assign mem_we = (st_q == rs485_pkg::ST_EXEC) && op_q == rs485_pkg::OP_RXB && busen_q
		&& mode_q == rs485_pkg::MODE_RX && !ready_q && rx_cnt_q < CW'(MAX_FRAME);
	assign mem_addr = mem_we ? rx_cnt_q[AW-1:0] : rd_idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= rxb_q;
		rd_data_s1 <= mem[mem_addr];
	end

	logic rd_ok;
	assign rd_ok = ready_q && LW'(cap_q) >= LW'(rx_cnt_q)
		&& CW'(rd_idx_q) < rx_cnt_q;

	// datapath and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_q <= 22'd9600; stop2_q <= 1'b0; par_q <= 1'b0;
			enhi_q <= 1'b1; busen_q <= 1'b0;
			mode_q <= rs485_pkg::MODE_IDLE; ready_q <= 1'b0; dir_q <= 1'b0;
			rx_cnt_q <= '0; rd_idx_q <= '0; dl_q <= '0; last_q <= '0;
			gap_q <= 32'd5209; gap_pend_q <= 1'b0; div_gap_q <= 1'b0;
			cnt_sent_q <= '0; cnt_rcv_q <= '0; cnt_ovf_q <= '0; cnt_wr_q <= '0;
			acc_q <= 1'b0; last_of_q <= 1'b0; dat_q <= '0; div_cnt_q <= '0;
		end else begin
			// config writes
			if (cfg_fire) begin
				case (rs485_pkg::reg_idx_t'(cfg.index))
					rs485_pkg::REG_BAUD:   begin baud_q <= cfg.data[21:0]; gap_pend_q <= 1'b1; end
					rs485_pkg::REG_STOP2:  begin stop2_q <= cfg.data[0]; gap_pend_q <= 1'b1; end
					rs485_pkg::REG_PARITY: begin par_q <= cfg.data[0]; gap_pend_q <= 1'b1; end
					rs485_pkg::REG_ENHI:   enhi_q <= cfg.data[0];
					rs485_pkg::REG_BUSEN:  busen_q <= cfg.data[0];
					default: ;
				endcase
			end
			case (st_q)
				rs485_pkg::ST_IDLE: begin
					if (gap_pend_q) begin
						gap_pend_q <= 1'b0;
						div_gap_q  <= 1'b1;
						div_cnt_q  <= 7'(QB - 1);
					end else if (in_fire) begin
						div_gap_q <= 1'b0;
						div_cnt_q <= 7'(QB - 1);
					end
				end
				rs485_pkg::ST_EXEC: begin
					acc_q <= (op_q == rs485_pkg::OP_TX) && tx_go;
					last_of_q <= 1'b0; dat_q <= '0;
					case (rs485_pkg::opcode_t'(op_q))
						rs485_pkg::OP_TICK: if (busen_q) begin
							// deadline passed: release the bus and listen; the gap cannot
							// have run out at the same tick
							if (mode_q == rs485_pkg::MODE_TX
								&& (now_q - dl_q) < 32'h8000_0000) begin
								dir_q <= ~enhi_q; mode_q <= rs485_pkg::MODE_RX; last_q <= now_q;
							end else if (mode_q == rs485_pkg::MODE_RX && !ready_q
								&& rx_cnt_q != '0 && (now_q - last_q) >= gap_q) begin
								ready_q <= 1'b1; rd_idx_q <= '0;
								mode_q <= rs485_pkg::MODE_IDLE; cnt_rcv_q <= cnt_rcv_q + 32'd1;
							end
						end
						rs485_pkg::OP_RXB: if (busen_q && mode_q == rs485_pkg::MODE_RX && !ready_q) begin
							if (rx_cnt_q >= CW'(MAX_FRAME)) begin
								cnt_ovf_q <= cnt_ovf_q + 32'd1;
								dir_q <= ~enhi_q; mode_q <= rs485_pkg::MODE_IDLE;
								ready_q <= 1'b0; rx_cnt_q <= '0; rd_idx_q <= '0;
							end else begin
								rx_cnt_q <= rx_cnt_q + CW'(1); last_q <= now_q;
							end
						end
						rs485_pkg::OP_TX: if (tx_ok) begin
							rx_cnt_q <= '0; rd_idx_q <= '0;
							if (sw_q) begin
								cnt_wr_q <= cnt_wr_q + 32'd1; dir_q <= ~enhi_q;
							end else begin
								cnt_sent_q <= cnt_sent_q + 32'd1; dir_q <= enhi_q;
								mode_q <= rs485_pkg::MODE_TX;
							end
						end
						rs485_pkg::OP_READ: ;
						rs485_pkg::OP_ABORT: begin
							dir_q <= ~enhi_q; mode_q <= rs485_pkg::MODE_IDLE;
							ready_q <= 1'b0; rx_cnt_q <= '0; rd_idx_q <= '0;
						end
						default: ;
					endcase
				end
				rs485_pkg::ST_DIV: div_cnt_q <= div_cnt_q - 7'd1;
				rs485_pkg::ST_FIN: begin
					if (div_gap_q) gap_q <= dur;
					else if (op_q == rs485_pkg::OP_TX && acc_q) dl_q <= now_q + dur;
					// read completes with the registered memory word
					if (!div_gap_q && op_q == rs485_pkg::OP_READ && rd_ok) begin
						acc_q <= 1'b1; dat_q <= rd_data_s1;
						if (CW'(rd_idx_q) + CW'(1) >= rx_cnt_q) begin
							last_of_q <= 1'b1; rx_cnt_q <= '0; rd_idx_q <= '0; ready_q <= 1'b0;
						end else rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// item latch and divider
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= in_ch.opcode; now_q <= in_ch.now_us; rxb_q <= in_ch.received_byte;
			len_q <= in_ch.tx_length; sw_q <= in_ch.write_short; cap_q <= in_ch.capacity;
		end
		if (st_q == rs485_pkg::ST_EXEC || (st_q == rs485_pkg::ST_IDLE && gap_pend_q)) begin
			num_q <= (st_q == rs485_pkg::ST_IDLE) ? dividend(10'd5, bpc, baud_q) : bits_w;
			rem_q <= '0;
			quo_q <= '0;
		end else if (st_q == rs485_pkg::ST_DIV) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (rem_sh >= {{(NW-21){1'b0}}, divisor}) begin
				rem_q <= NW'(rem_sh - {{(NW-21){1'b0}}, divisor});
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[NW-1:0];
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
		end
	end

	// EXEC -> FIN skips the divider unless a transmit is accepted
	// (ST_EXEC goes through ST_DIV only for accepted transmits)
	assign out_ch.valid                = (st_q == rs485_pkg::ST_OUT);
	assign out_ch.accepted             = acc_q;
	assign out_ch.drive_enable         = dir_q;
	assign out_ch.bus_mode             = mode_q;
	assign out_ch.frame_ready          = ready_q;
	assign out_ch.frame_length         = 9'(rx_cnt_q);
	assign out_ch.data_byte            = dat_q;
	assign out_ch.last_of_frame        = last_of_q;
	assign out_ch.sent_frame_count     = cnt_sent_q;
	assign out_ch.received_frame_count = cnt_rcv_q;
	assign out_ch.overflow_count       = cnt_ovf_q;
	assign out_ch.write_error_count    = cnt_wr_q;
endmodule

// ===== rtl/rs485_checker.sv =====
// Checker: port-level properties of the RS485 frame transport core.
module rs485_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic out_acc,
	input logic out_frame_ready,
	input logic [1:0] out_mode
);
	// no new word is taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// a last marker comes only with an accepted read
	a_last_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_acc) else $error("last without accept");
	// after the final read no frame is left
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> !out_frame_ready) else $error("frame kept after last");
	// a held result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	// a ready frame means idle mode
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_frame_ready |-> out_mode == 2'd0) else $error("ready not idle");
endmodule

bind rs485_half_duplex_frame_transport_core rs485_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.last_of_frame), .out_acc(out_ch.accepted),
	.out_frame_ready(out_ch.frame_ready), .out_mode(out_ch.bus_mode)
);
